[rtl/core/psch_pkg.sv]
`default_nettype none
package psch_pkg;

    // fixed field widths of the item ports
    localparam int SLOT_ID_W = 4;
    localparam int PRIO_IN_W = 8;
    localparam int BURST_IN_W = 16;
    localparam int TIME_W = 32;

    // default sizes handed to the top level
    localparam int DEF_MAX_TASKS = 16;
    localparam int DEF_PRIO_BITS = 8;
    localparam int DEF_BURST_BITS = 16;

    // request codes
    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // saturating increment of a time or idle counter
    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        logic [TIME_W-1:0] r;
        r = (v == {TIME_W{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/preemptive_priority_scheduler_unit.sv]
`default_nettype none
// channel   direction  handshake             payload
// request   in         i_valid / o_ready     i_req_type i_slot_id i_task_priority i_burst_length
// result    out        o_valid / i_ready     o_accepted o_running_slot o_cpu_idle o_first_run
//                                            o_finished o_now_time o_idle_ticks
//
// an arrival passes through S_ARR; a tick passes through S_SCAN and then S_UPD, with the
// one comparator walking the slot memory an entry a cycle through its registered read port
// reset (synchronous, active low) clears busy and started bits and both counters; slot
// memory contents are left as they are and read only behind a busy bit
// a finished result waits in the output register while the next request is taken; that
// request's final step holds until the result register is free
module preemptive_priority_scheduler_unit #(
    parameter int MAX_TASKS = psch_pkg::DEF_MAX_TASKS,
    parameter int PRIO_BITS = psch_pkg::DEF_PRIO_BITS,
    parameter int BURST_BITS = psch_pkg::DEF_BURST_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_req_type,
    input  wire logic [psch_pkg::SLOT_ID_W-1:0]   i_slot_id,
    input  wire logic [psch_pkg::PRIO_IN_W-1:0]   i_task_priority,
    input  wire logic [psch_pkg::BURST_IN_W-1:0]  i_burst_length,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_accepted,
    output logic      [psch_pkg::SLOT_ID_W-1:0]   o_running_slot,
    output logic                                  o_cpu_idle,
    output logic                                  o_first_run,
    output logic                                  o_finished,
    output logic      [psch_pkg::TIME_W-1:0]      o_now_time,
    output logic      [psch_pkg::TIME_W-1:0]      o_idle_ticks
);

    import psch_pkg::*;

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W = SLOT_W + 1;
    localparam int WORD_W = PRIO_BITS + TIME_W + BURST_BITS;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_TASKS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ARR  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]             r_state;
    logic [SLOT_ID_W-1:0]   r_slot;
    logic [PRIO_BITS-1:0]   r_prio;
    logic [BURST_BITS-1:0]  r_burst;
    logic [MAX_TASKS-1:0]   r_busy;
    logic [MAX_TASKS-1:0]   r_started;
    logic [TIME_W-1:0]      r_time;
    logic [TIME_W-1:0]      r_idle;

    logic [CNT_W-1:0]       r_idx;
    logic                   r_cmp_vld;
    logic [SLOT_W-1:0]      r_cmp_idx;
    logic                   r_best_vld;
    logic [SLOT_W-1:0]      r_best_idx;
    logic [PRIO_BITS-1:0]   r_best_prio;
    logic [TIME_W-1:0]      r_best_arr;
    logic [BURST_BITS-1:0]  r_best_rem;

    logic                   r_o_valid;
    logic                   r_o_acc;
    logic [SLOT_ID_W-1:0]   r_o_slot;
    logic                   r_o_idle;
    logic                   r_o_first;
    logic                   r_o_fin;

    logic                   in_xfer;
    logic                   out_free;
    logic [SLOT_W-1:0]      arr_addr;
    logic                   arr_ok;
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;
    logic [PRIO_BITS-1:0]   rd_prio;
    logic [TIME_W-1:0]      rd_arr;
    logic [BURST_BITS-1:0]  rd_rem;
    logic                   cmp_win;
    logic [BURST_BITS-1:0]  rem_dec;

    assign in_xfer  = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_o_valid || i_ready;

    // arrival admission: slot in range, slot free, non-zero burst
    assign arr_addr = SLOT_W'(r_slot);
    assign arr_ok   = ({{(TIME_W-SLOT_ID_W){1'b0}}, r_slot} < TIME_W'(MAX_TASKS))
                      && !r_busy[arr_addr] && (r_burst != '0);

    // slot memory fields
    assign {rd_prio, rd_arr, rd_rem} = ram_rdata;
    assign rem_dec = r_best_rem - 1'b1;

    // candidate beats current best: lower priority, then earlier arrival
    assign cmp_win = r_busy[r_cmp_idx] &&
                     (!r_best_vld || (rd_prio < r_best_prio) ||
                      ((rd_prio == r_best_prio) && (rd_arr < r_best_arr)));

    // memory write: install on arrival, write back remaining work on tick
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = arr_addr;
        ram_wdata = {r_prio, r_time, r_burst};
        case (r_state)
            S_ARR: begin
                ram_we = out_free && arr_ok;
            end
            S_UPD: begin
                ram_we    = out_free && r_best_vld;
                ram_waddr = r_best_idx;
                ram_wdata = {r_best_prio, r_best_arr, rem_dec};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    psch_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TASKS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_slot  <= i_slot_id;
            r_prio  <= PRIO_BITS'(i_task_priority);
            r_burst <= BURST_BITS'(i_burst_length);
        end
    end

    // scan datapath: one slot compared per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_cmp_idx <= r_idx[SLOT_W-1:0];
            if (r_idx != LAST_CNT) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_cmp_vld && cmp_win) begin
                r_best_idx  <= r_cmp_idx;
                r_best_prio <= rd_prio;
                r_best_arr  <= rd_arr;
                r_best_rem  <= rd_rem;
            end
        end else begin
            r_idx <= '0;
        end
    end

    // sequencer, slot flags, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_busy     <= '0;
            r_started  <= '0;
            r_time     <= '0;
            r_idle     <= '0;
            r_cmp_vld  <= 1'b0;
            r_best_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cmp_vld  <= 1'b0;
                    r_best_vld <= 1'b0;
                    if (in_xfer) begin
                        r_state <= (i_req_type == REQ_TICK) ? S_SCAN : S_ARR;
                    end
                end
                S_ARR: begin
                    if (out_free) begin
                        if (arr_ok) begin
                            r_busy[arr_addr]    <= 1'b1;
                            r_started[arr_addr] <= 1'b0;
                        end
                        r_o_valid <= 1'b1;
                        r_o_acc   <= arr_ok;
                        r_o_slot  <= '0;
                        r_o_idle  <= 1'b0;
                        r_o_first <= 1'b0;
                        r_o_fin   <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= (r_idx != LAST_CNT);
                    if (r_cmp_vld && cmp_win) begin
                        r_best_vld <= 1'b1;
                    end
                    if (r_idx == LAST_CNT) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_acc   <= 1'b0;
                        r_time    <= sat_inc(r_time);
                        if (r_best_vld) begin
                            r_o_slot  <= SLOT_ID_W'(r_best_idx);
                            r_o_idle  <= 1'b0;
                            r_o_first <= !r_started[r_best_idx];
                            r_o_fin   <= (rem_dec == '0);
                            r_started[r_best_idx] <= (rem_dec != '0);
                            if (rem_dec == '0) begin
                                r_busy[r_best_idx] <= 1'b0;
                            end
                        end else begin
                            r_o_slot  <= '0;
                            r_o_idle  <= 1'b1;
                            r_o_first <= 1'b0;
                            r_o_fin   <= 1'b0;
                            r_idle    <= sat_inc(r_idle);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign o_valid        = r_o_valid;
    assign o_accepted     = r_o_acc;
    assign o_running_slot = r_o_slot;
    assign o_cpu_idle     = r_o_idle;
    assign o_first_run    = r_o_first;
    assign o_finished     = r_o_fin;
    assign o_now_time     = r_time;
    assign o_idle_ticks   = r_idle;

endmodule
`default_nettype wire

[rtl/core/psch_ram.sv]
`default_nettype none
module psch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
